/* design/pfc_pkg.sv */
`default_nettype none

package pfc_pkg;

   localparam int SIDE     = 5;
   localparam int CELLS    = SIDE * SIDE;
   localparam int NLETTERS = 26;
   localparam int LETTER_W = 5;
   localparam int CELL_W   = $clog2(CELLS + 1);
   localparam int COORD_W  = $clog2(SIDE);

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [CELL_W-1:0]   cell_type;
   typedef logic [COORD_W-1:0]  coord_type;

   localparam letter_type CODE_I    = letter_type'(8);
   localparam letter_type CODE_J    = letter_type'(9);
   localparam letter_type CODE_Q    = letter_type'(16);
   localparam letter_type CODE_X    = letter_type'(23);
   localparam letter_type CODE_LAST = letter_type'(NLETTERS - 1);

   // request kinds carried on tuser
   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_TEXT = 1'b1;

   typedef struct packed {
      logic accept;
      logic key_place;
      logic walk_start;
      logic walk_place;
      logic step;
      logic out_first;
      logic out_second;
   } dp_cmd_type;

   typedef struct packed {
      logic item_last;
      logic step_pair;
      logic step_done;
      logic walk_end;
      logic rsp_free;
   } dp_status_type;

   function automatic coord_type cell_row(cell_type p);
      coord_type r;
      r = '0;
      for (int i = 1; i < SIDE; i++) begin
         if (p >= cell_type'(i * SIDE)) r = coord_type'(i);
      end
      return r;
   endfunction

   function automatic coord_type cell_col(cell_type p);
      cell_type base;
      base = cell_type'(int'(cell_row(p)) * SIDE);
      return coord_type'(p - base);
   endfunction

   function automatic cell_type cell_at(coord_type r, coord_type c);
      return cell_type'(int'(r) * SIDE + int'(c));
   endfunction

   function automatic coord_type next_coord(coord_type c);
      return (c == coord_type'(SIDE - 1)) ? '0 : c + 1'b1;
   endfunction

   function automatic letter_type filler_for(letter_type code);
      return (code == CODE_X) ? CODE_Q : CODE_X;
   endfunction

endpackage

`default_nettype wire

/* design/pfc_datapath.sv */
`default_nettype none

module pfc_datapath (
   input  wire                      clock,
   input  wire                      reset,
   input  wire pfc_pkg::letter_type req_letter,
   input  wire                      req_last,
   input  wire                      rsp_tready,
   input  wire pfc_pkg::dp_cmd_type cmd,
   output pfc_pkg::dp_status_type   status,
   output logic                     rsp_valid,
   output pfc_pkg::letter_type      rsp_letter,
   output logic                     rsp_last,
   output logic                     rsp_end
);
   import pfc_pkg::*;

   // item registers
   letter_type item_code_ff;
   logic       item_ok_ff, item_last_ff, consumed_ff;

   // square build state
   logic [NLETTERS-1:0] mask_ff, mask_in;
   cell_type            fill_ff, fill_in;
   letter_type          walk_ff;

   // open pair
   letter_type pend_ff;
   logic       pv_ff;

   // pair under encryption
   letter_type pa_ff, pb_ff;
   logic       pair_final_ff, pair_end_ff;

   // memories with reset-valid bits
   cell_type            pos_mem [NLETTERS];
   logic [NLETTERS-1:0] pos_vld_ff;
   letter_type          sq_mem [CELLS];
   logic [CELLS-1:0]    sq_vld_ff;

   cell_type   pos_a_ff, pos_b_ff;
   logic       pos_va_ff, pos_vb_ff;
   cell_type   o1_ff, o2_ff;
   letter_type sq1_ff, sq2_ff;
   logic       sq_v1_ff, sq_v2_ff;

   logic       rsp_valid_ff, rsp_last_ff, rsp_end_ff;
   letter_type rsp_letter_ff;

   // placement
   letter_type place_code;
   logic       place_try, restart, place_en;
   logic [NLETTERS-1:0] mask_eff;
   cell_type   fill_eff;

   always_comb begin
      place_code = cmd.walk_place ? walk_ff : item_code_ff;
      place_try  = (cmd.key_place & item_ok_ff) | (cmd.walk_place & (walk_ff != CODE_J));
      restart    = cmd.key_place & item_ok_ff & (fill_ff == cell_type'(CELLS));
      mask_eff   = restart ? '0 : mask_ff;
      fill_eff   = restart ? '0 : fill_ff;
      place_en   = place_try && !mask_eff[place_code] && (fill_eff != cell_type'(CELLS));
      mask_in    = mask_eff;
      fill_in    = fill_eff;
      if (place_en) begin
         mask_in[place_code] = 1'b1;
         fill_in             = fill_eff + 1'b1;
      end
   end

   // pairing
   logic       eq, step_pair, step_done, step_final;
   letter_type step_b;

   always_comb begin
      eq = (pend_ff == item_code_ff);
      if (!consumed_ff) begin
         step_pair  = item_ok_ff & pv_ff;
         step_b     = eq ? filler_for(pend_ff) : item_code_ff;
         step_final = !(item_last_ff & eq);
      end else begin
         step_pair  = item_last_ff & pv_ff;
         step_b     = filler_for(pend_ff);
         step_final = 1'b1;
      end
      step_done = consumed_ff & !(item_last_ff & pv_ff);
   end

   // encryption rules
   cell_type  p1, p2, o1, o2;
   coord_type r1, c1, r2, c2;

   always_comb begin
      p1 = (pos_va_ff && pos_a_ff < cell_type'(CELLS)) ? pos_a_ff : '0;
      p2 = (pos_vb_ff && pos_b_ff < cell_type'(CELLS)) ? pos_b_ff : '0;
      r1 = cell_row(p1);
      c1 = cell_col(p1);
      r2 = cell_row(p2);
      c2 = cell_col(p2);
      if (r1 == r2) begin
         o1 = cell_at(r1, next_coord(c1));
         o2 = cell_at(r2, next_coord(c2));
      end else if (c1 == c2) begin
         o1 = cell_at(next_coord(r1), c1);
         o2 = cell_at(next_coord(r2), c2);
      end else begin
         o1 = cell_at(r1, c2);
         o2 = cell_at(r2, c1);
      end
   end

   // control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         fill_ff      <= '0;
         pv_ff        <= 1'b0;
         pend_ff      <= '0;
         consumed_ff  <= 1'b0;
         pos_vld_ff   <= '0;
         sq_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.key_place || cmd.walk_place) begin
            mask_ff <= mask_in;
            fill_ff <= fill_in;
         end
         if (place_en) begin
            pos_vld_ff[place_code] <= 1'b1;
            sq_vld_ff[fill_eff]    <= 1'b1;
         end
         if (cmd.accept) consumed_ff <= 1'b0;
         if (cmd.step) begin
            consumed_ff <= 1'b1;
            if (!consumed_ff) begin
               if (item_ok_ff) begin
                  if (!pv_ff) begin
                     pend_ff <= item_code_ff;
                     pv_ff   <= 1'b1;
                  end else if (eq) begin
                     pend_ff <= item_code_ff;
                  end else begin
                     pv_ff <= 1'b0;
                  end
               end
            end else if (item_last_ff) begin
               pv_ff   <= 1'b0;
               pend_ff <= '0;
            end
         end
         if (cmd.out_first || cmd.out_second) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers and memories
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_code_ff <= (req_letter == CODE_J) ? CODE_I : req_letter;
         item_ok_ff   <= (req_letter < letter_type'(NLETTERS));
         item_last_ff <= req_last;
      end
      if (cmd.walk_start) walk_ff <= '0;
      else if (cmd.walk_place) walk_ff <= walk_ff + 1'b1;
      if (place_en) begin
         sq_mem[fill_eff]    <= place_code;
         pos_mem[place_code] <= fill_eff;
      end
      if (cmd.step && step_pair) begin
         pa_ff         <= pend_ff;
         pb_ff         <= step_b;
         pair_final_ff <= step_final;
         pair_end_ff   <= step_final & item_last_ff;
      end
      pos_a_ff  <= pos_mem[pa_ff];
      pos_b_ff  <= pos_mem[pb_ff];
      pos_va_ff <= pos_vld_ff[pa_ff];
      pos_vb_ff <= pos_vld_ff[pb_ff];
      o1_ff     <= o1;
      o2_ff     <= o2;
      sq1_ff    <= sq_mem[o1_ff];
      sq2_ff    <= sq_mem[o2_ff];
      sq_v1_ff  <= sq_vld_ff[o1_ff];
      sq_v2_ff  <= sq_vld_ff[o2_ff];
      if (cmd.out_first) begin
         rsp_letter_ff <= sq_v1_ff ? sq1_ff : '0;
         rsp_last_ff   <= 1'b0;
         rsp_end_ff    <= 1'b0;
      end else if (cmd.out_second) begin
         rsp_letter_ff <= sq_v2_ff ? sq2_ff : '0;
         rsp_last_ff   <= pair_final_ff;
         rsp_end_ff    <= pair_end_ff;
      end
   end

   assign status.item_last = item_last_ff;
   assign status.step_pair = step_pair;
   assign status.step_done = step_done;
   assign status.walk_end  = (walk_ff == CODE_LAST);
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_letter = rsp_letter_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_end    = rsp_end_ff;

endmodule

`default_nettype wire

/* design/pfc_control.sv */
`default_nettype none

module pfc_control (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   input  wire                         req_kind,
   input  wire pfc_pkg::dp_status_type status,
   output logic                        req_tready,
   output pfc_pkg::dp_cmd_type         cmd
);
   import pfc_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_KEY  = 4'd1;
   localparam logic [3:0] S_WALK = 4'd2;
   localparam logic [3:0] S_STEP = 4'd3;
   localparam logic [3:0] S_POS  = 4'd4;
   localparam logic [3:0] S_CELL = 4'd5;
   localparam logic [3:0] S_SQR  = 4'd6;
   localparam logic [3:0] S_OUT1 = 4'd7;
   localparam logic [3:0] S_OUT2 = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = (req_kind == REQ_KEY) ? S_KEY : S_STEP;
            end
         end
         S_KEY: begin
            cmd.key_place  = 1'b1;
            cmd.walk_start = 1'b1;
            state_in       = status.item_last ? S_WALK : S_IDLE;
         end
         S_WALK: begin
            cmd.walk_place = 1'b1;
            if (status.walk_end) state_in = S_IDLE;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            if (status.step_pair) state_in = S_POS;
            else if (status.step_done) state_in = S_IDLE;
         end
         S_POS:  state_in = S_CELL;
         S_CELL: state_in = S_SQR;
         S_SQR:  state_in = S_OUT1;
         S_OUT1: begin
            if (status.rsp_free) begin
               cmd.out_first = 1'b1;
               state_in      = S_OUT2;
            end
         end
         S_OUT2: begin
            if (status.rsp_free) begin
               cmd.out_second = 1'b1;
               state_in       = S_STEP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* design/playfair_digraph_cipher.sv */
// Sequence: once accepted, a pair's first letter passes the step, position, cell, square and
// first output states, with a further step state when only the end marker closes the pair; the
// second letter comes from the second output state. Intake: one request in flight. A key request
// adds an alphabet walk on the key's last letter; a text request adds the pair states for each
// pair it closes, and any output stalls; a waiting final letter does not block intake.
// Reset: synchronous, active high; clears control, placed set, fill count and open pair.
`default_nettype none

module playfair_digraph_cipher (
   input  wire        clock,
   input  wire        reset,
   // request channel
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [4:0] letter, [7:5] zero
   input  wire        req_tuser,   // [0] req_type: 0 key letter, 1 plaintext letter
   input  wire        req_tlast,   // is_last
   // result channel
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [4:0] cipher_letter, [7:5] zero
   output logic       rsp_tuser,   // [0] message_end
   output logic       rsp_tlast    // run_last
);
   import pfc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   letter_type    rsp_letter;

   // Sequencer: takes one request, steps the pairing logic and drives the
   // pair through the position and square memories.
   pfc_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   // Square and letter-position memories, pairing state and the output register.
   // Cells and positions never written since reset read as letter A / cell 0.
   pfc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_letter (req_tdata[LETTER_W-1:0]),
      .req_last   (req_tlast),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_letter (rsp_letter),
      .rsp_last   (rsp_tlast),
      .rsp_end    (rsp_tuser)
   );

   // pad the letter up to a whole byte
   assign rsp_tdata = {{(8 - LETTER_W){1'b0}}, rsp_letter};

endmodule

`default_nettype wire

/* design/pfc_checker.sv */
`default_nettype none

module pfc_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_tvalid,
   input wire       req_tready,
   input wire [7:0] req_tdata,
   input wire       req_tuser,
   input wire       req_tlast,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata,
   input wire       rsp_tuser,
   input wire       rsp_tlast
);
   import pfc_pkg::*;

   // message end only ever marks the final letter of a request
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("message end without run last");

   // the square never holds J, so J never comes out
   a_no_j: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] != CODE_J) && (rsp_tdata[7:5] == 3'b000))
      else $error("cipher letter out of alphabet");

   // a key letter produces no result right after it is taken
   a_key_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_KEY) |=> !$rose(rsp_tvalid))
      else $error("result after key letter");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (.*);

`default_nettype wire
